/* design/ffha_pkg.sv */
package ffha_pkg;

  localparam int HeapBytes   = 65536;
  localparam int HeaderBytes = 16;
  localparam int MinBlock    = 8;
  localparam int OffW        = 17;
  // headers sit on 8-byte boundaries: index = offset / 8
  localparam int IdxW        = 13;

  typedef logic [OffW-1:0] off_t;
  typedef logic [IdxW-1:0] idx_t;

  // one header: next offset, free mark, size
  typedef struct packed {
    off_t nxt;
    logic fre;
    off_t size;
  } hdr_t;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNull    = 2'd1;
  localparam logic [1:0] StNoFit   = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // header offsets stay below the heap top, so the index fits IdxW bits
  function automatic idx_t off2idx(input off_t o);
    return o[IdxW+2:3];
  endfunction

endpackage

/* design/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator with coalescing.
// The heap is a chain of headers kept in one header RAM, addressed by
// byte offset / 8; each header holds its size, a free mark and the offset
// of the next header (end of heap meaning none).
// Command channel: pulse start while busy is low with in_command
// (allocate or free), in_request_size and in_release_offset.
// Result: out_valid is high for one cycle with out_status and
// out_payload_offset; the receiver cannot stall, so no holding stage.
// Each header visited on the walk takes a RAM read state, then an
// inspect state; a null or failed request then finishes, an allocate
// does split and write-back, and a free does next-header read, merge
// checks and write-back. out_valid is registered from the final state.
// One request at a time; busy is low again in the out_valid cycle.
// The RAM read port sets the walk speed.
// Reset (rst_n low, synchronous) sets heap_bytes to 65536 and arms one
// free header at offset 0; the header is written in the init state,
// and busy is high meanwhile. A heap_bytes write over
// the APB port does the same for the new size.
module first_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_release_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffha_pkg::*;

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_NRD   = 11'b00000010000,
    S_NCHK  = 11'b00000100000,
    S_WB1   = 11'b00001000000,
    S_WB2   = 11'b00010000000,
    S_DONE  = 11'b00100000000,
    S_PRD   = 11'b01000000000,
    S_PCHK  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  off_t   heap_r, heap_nxt;
  off_t   cur_r, cur_nxt;      // header being visited
  off_t   prev_r, prev_nxt;    // header before it
  logic   prev_ok_r, prev_ok_nxt;
  hdr_t   curh_r, curh_nxt;    // copy of current header
  hdr_t   prevh_r, prevh_nxt;
  hdr_t   nh_r, nh_nxt;        // next header (free path)
  logic   cmd_r;
  off_t   sz_r;
  off_t   rel_r;
  logic [1:0] st_r, st_nxt;
  off_t   po_r, po_nxt;
  logic   ov_r;

  logic   we;
  idx_t   waddr, raddr;
  hdr_t   wdata, rdata;

  ffha_hdr_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic cfg_wr;
  off_t clamped;
  assign cfg_wr = psel & penable & pwrite & ~paddr;
  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : {15'd0, heap_r};

  always_comb begin
    clamped = pwdata[OffW-1:0];
    if (clamped < off_t'(HeaderBytes + MinBlock)) clamped = off_t'(HeaderBytes + MinBlock);
    else if (clamped > off_t'(HeapBytes)) clamped = off_t'(HeapBytes);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_payload_offset = po_r[15:0];

  // walk and write-back sequencer
  off_t split_off;
  off_t cur_pay;
  assign split_off = cur_r + off_t'(HeaderBytes) + sz_r;
  assign cur_pay   = cur_r + off_t'(HeaderBytes);

  always_comb begin
    state_nxt = state_r; heap_nxt = heap_r; cur_nxt = cur_r; prev_nxt = prev_r;
    prev_ok_nxt = prev_ok_r; curh_nxt = curh_r; prevh_nxt = prevh_r; nh_nxt = nh_r;
    st_nxt = st_r; po_nxt = po_r;
    we = 1'b0; waddr = off2idx(cur_r); wdata = curh_r; raddr = off2idx(cur_r);
    case (state_r)
      S_INIT: begin
        we = 1'b1; waddr = '0;
        wdata = '{nxt: heap_r, fre: 1'b1, size: heap_r - off_t'(HeaderBytes)};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cur_nxt = '0; prev_ok_nxt = 1'b0; po_nxt = '0;
        if (start) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        curh_nxt = rdata;
        if (cmd_r == CmdAlloc) begin
          if (sz_r == '0) begin
            st_nxt = StNull; state_nxt = S_DONE;
          end else if (rdata.fre && rdata.size >= sz_r) begin
            st_nxt = StOk; po_nxt = cur_pay;
            if (rdata.size >= sz_r + off_t'(HeaderBytes + MinBlock)) begin
              we = 1'b1; waddr = off2idx(split_off);
              wdata = '{nxt: rdata.nxt, fre: 1'b1,
                        size: rdata.size - sz_r - off_t'(HeaderBytes)};
              curh_nxt = '{nxt: split_off, fre: 1'b0, size: sz_r};
            end else begin
              curh_nxt.fre = 1'b0;
            end
            state_nxt = S_WB1;
          end else if (rdata.nxt >= heap_r) begin
            st_nxt = StNoFit; state_nxt = S_DONE;
          end else begin
            prev_nxt = cur_r; prevh_nxt = rdata; prev_ok_nxt = 1'b1;
            cur_nxt = rdata.nxt; state_nxt = S_RD;
          end
        end else begin
          if (rel_r == '0) begin
            st_nxt = StNull; state_nxt = S_DONE;
          end else if (cur_pay == rel_r) begin
            st_nxt = StOk;
            if (rdata.nxt < heap_r) state_nxt = S_NRD;
            else begin
              nh_nxt = '0; state_nxt = S_NCHK;
            end
          end else if (rdata.nxt >= heap_r || cur_pay > rel_r) begin
            st_nxt = StUnknown; state_nxt = S_DONE;
          end else begin
            prev_nxt = cur_r; prevh_nxt = rdata; prev_ok_nxt = 1'b1;
            cur_nxt = rdata.nxt; state_nxt = S_RD;
          end
        end
      end
      S_NRD: begin
        raddr = off2idx(curh_r.nxt); state_nxt = S_PRD;
      end
      S_PRD: begin
        nh_nxt = rdata; state_nxt = S_NCHK;
      end
      S_NCHK: begin
        // merge with a free next neighbour; the previous one follows in S_PCHK
        if (curh_r.fre) state_nxt = S_DONE;
        else begin
          if (nh_r.fre && curh_r.nxt < heap_r) begin
            curh_nxt.size = curh_r.size + off_t'(HeaderBytes) + nh_r.size;
            curh_nxt.nxt  = nh_r.nxt;
          end
          curh_nxt.fre = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (prev_ok_r && prevh_r.fre) begin
          we = 1'b1; waddr = off2idx(prev_r);
          wdata = '{nxt: curh_r.nxt, fre: 1'b1,
                    size: prevh_r.size + off_t'(HeaderBytes) + curh_r.size};
          state_nxt = S_DONE;
        end else state_nxt = S_WB1;
      end
      S_WB1: begin
        we = 1'b1; waddr = off2idx(cur_r); wdata = curh_r; state_nxt = S_WB2;
      end
      S_WB2: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr) begin
      heap_nxt = clamped; state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; heap_r <= off_t'(HeapBytes); ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; heap_r <= heap_nxt;
      ov_r <= (state_r == S_DONE);
    end
    cur_r <= cur_nxt; prev_r <= prev_nxt; prev_ok_r <= prev_ok_nxt;
    curh_r <= curh_nxt; prevh_r <= prevh_nxt; nh_r <= nh_nxt;
    st_r <= st_nxt; po_r <= (state_r == S_DONE && st_r != StOk) ? '0 : po_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_command;
      sz_r  <= {1'b0, in_request_size + 16'd7} & ~off_t'(7)
               | (in_request_size > 16'hFFF8 ? off_t'(HeapBytes) : '0);
      rel_r <= {1'b0, in_release_offset};
    end
  end

endmodule

/* design/ffha_hdr_ram.sv */
module ffha_hdr_ram (
  input  logic                clk,
  input  logic                we,
  input  ffha_pkg::idx_t      waddr,
  input  ffha_pkg::hdr_t      wdata,
  input  ffha_pkg::idx_t      raddr,
  output ffha_pkg::hdr_t      rdata
);
  import ffha_pkg::*;

  hdr_t mem [0:(1<<IdxW)-1];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
